### rtl/rnh_pkg.sv
// ----------------------------------------------------------------------------
// rnh_pkg
// Shared types and constants of the range normalised histogram unit.
// ----------------------------------------------------------------------------
package rnh_pkg;

  localparam int CHANNELS   = 4;
  localparam int BINS       = 256;
  localparam int COUNT_BITS = 32;
  localparam int CH_BITS    = 2;
  localparam int BIN_BITS   = 8;
  localparam int ADDR_BITS  = CH_BITS + BIN_BITS;
  localparam int DEPTH      = CHANNELS * BINS;
  localparam int PROD_BITS  = 41;

  localparam logic signed [31:0] EMPTY_MIN = 32'sh7fff_ffff;
  localparam logic signed [31:0] EMPTY_MAX = 32'sh8000_0000;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_RANGE = 2'd1,
    OP_BIN   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [BIN_BITS-1:0]   bin_index;
    logic [31:0]           bin_count;
    logic signed [31:0]    channel_min;
    logic signed [31:0]    channel_max;
    logic signed [31:0]    global_min;
    logic signed [31:0]    global_max;
  } result_t;

endpackage

### rtl/rnh_if.sv
// ----------------------------------------------------------------------------
// rnh_in_if / rnh_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface rnh_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic [1:0]                    channel;
  logic signed [31:0]            sample_value;
  logic [7:0]                    bin_select;
  modport source (output valid, opcode, channel, sample_value, bin_select, input ready);
  modport sink (input valid, opcode, channel, sample_value, bin_select, output ready);
endinterface

interface rnh_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    bin_index;
  logic [31:0]                   bin_count;
  logic signed [31:0]            channel_min;
  logic signed [31:0]            channel_max;
  logic signed [31:0]            global_min;
  logic signed [31:0]            global_max;
  modport source (output valid, bin_index, bin_count, channel_min, channel_max,
                  global_min, global_max, input ready);
  modport sink (input valid, bin_index, bin_count, channel_min, channel_max,
                global_min, global_max, output ready);
endinterface

### rtl/range_normalized_histogram_unit.sv
// ----------------------------------------------------------------------------
// range_normalized_histogram_unit
// Per-channel 256-bin histogram with bins normalised to the global range.
// ----------------------------------------------------------------------------
// One word at a time. After reset, and after every clear word, a sweep zeroes
// all 1024 entries of the count memory (one entry a cycle) before the next word is
// taken. A clear or range word goes straight to its result word; a read passes
// the memory read, an idle write slot and the output. A bin word passes the
// bit-serial divider (load, 41 quotient bits, done) and then the memory
// read-modify-write. Output back pressure holds the result word until taken.
module range_normalized_histogram_unit (
  input  logic      clk,
  input  logic      rst,
  rnh_in_if.sink    in_w,
  rnh_out_if.source out_w
);
  rnh_pkg::state_t state, state_next;

  logic [rnh_pkg::COUNT_BITS-1:0] mem [rnh_pkg::DEPTH];
  logic [rnh_pkg::COUNT_BITS-1:0] rd_data;
  logic [rnh_pkg::ADDR_BITS-1:0]  rd_addr;
  logic [rnh_pkg::ADDR_BITS-1:0]  wr_addr;
  logic [rnh_pkg::COUNT_BITS-1:0] wr_data;
  logic                           wr_en;
  logic                           rd_en;
  logic [rnh_pkg::ADDR_BITS-1:0]  sweep;

  logic signed [31:0] cmin [rnh_pkg::CHANNELS];
  logic signed [31:0] cmax [rnh_pkg::CHANNELS];
  logic signed [31:0] gmin, gmax;

  logic [1:0]              op;
  logic [1:0]              ch;
  logic signed [31:0]      val;
  logic [7:0]              sel;
  logic [7:0]              idx;
  logic                    ch_ok;
  rnh_pkg::result_t        res;
  logic                    accept;

  logic                              div_start, div_done;
  logic [rnh_pkg::BIN_BITS-1:0]      div_q;
  logic [32:0]                       len;
  logic [32:0]                       vdiff;
  logic [rnh_pkg::PROD_BITS-1:0]     prod;
  logic                              below;

  assign accept = in_w.valid && in_w.ready;
  assign ch_ok  = 32'(ch) < 32'(rnh_pkg::CHANNELS);

  // global range over all channels
  always_comb begin
    gmin = rnh_pkg::EMPTY_MIN;
    gmax = rnh_pkg::EMPTY_MAX;
    for (int c = 0; c < rnh_pkg::CHANNELS; c++) begin
      if (cmin[c] < gmin) gmin = cmin[c];
      if (cmax[c] > gmax) gmax = cmax[c];
    end
  end

  always_comb begin
    logic signed [32:0] span;
    span  = 33'(gmax) - 33'(gmin);
    len   = (span < 33'sd1) ? 33'd1 : 33'(span);
    vdiff = 33'(33'(val) - 33'(gmin));
    below = val < gmin;
    prod  = rnh_pkg::PROD_BITS'(vdiff) * rnh_pkg::PROD_BITS'(rnh_pkg::BINS - 1);
  end

  rnh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (len),
    .done     (div_done),
    .quotient (div_q)
  );

  // divider loads in the first cycle after a bin word, once val is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= accept && in_w.opcode == rnh_pkg::OP_BIN;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rnh_pkg::ST_SWEEP: if (sweep == rnh_pkg::ADDR_BITS'(rnh_pkg::DEPTH - 1))
                           state_next = rnh_pkg::ST_IDLE;
      rnh_pkg::ST_IDLE: begin
        if (in_w.valid) begin
          case (rnh_pkg::op_t'(in_w.opcode))
            rnh_pkg::OP_BIN:  state_next = rnh_pkg::ST_DIV;
            rnh_pkg::OP_READ: state_next = rnh_pkg::ST_READ;
            default:          state_next = rnh_pkg::ST_OUT;
          endcase
        end
      end
      rnh_pkg::ST_DIV:   if (div_done) state_next = rnh_pkg::ST_READ;
      rnh_pkg::ST_READ:  state_next = rnh_pkg::ST_WRITE;
      rnh_pkg::ST_WRITE: state_next = rnh_pkg::ST_OUT;
      rnh_pkg::ST_OUT: begin
        if (out_w.ready)
          state_next = (op == rnh_pkg::OP_CLEAR) ? rnh_pkg::ST_SWEEP : rnh_pkg::ST_IDLE;
      end
      default: state_next = rnh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_w.ready = state == rnh_pkg::ST_IDLE;
    out_w.valid = state == rnh_pkg::ST_OUT;
    rd_en = state == rnh_pkg::ST_READ;
    rd_addr = {ch, idx};
    wr_addr = (state == rnh_pkg::ST_SWEEP) ? sweep : {ch, idx};
    wr_data = (state == rnh_pkg::ST_SWEEP) ? '0 :
              (rd_data == rnh_pkg::COUNT_MAX) ? rd_data : rd_data + 1'b1;
    wr_en = state == rnh_pkg::ST_SWEEP ||
            (state == rnh_pkg::ST_WRITE && op == rnh_pkg::OP_BIN && ch_ok);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rnh_pkg::ST_SWEEP;
      sweep <= '0;
      for (int c = 0; c < rnh_pkg::CHANNELS; c++) begin
        cmin[c] <= rnh_pkg::EMPTY_MIN;
        cmax[c] <= rnh_pkg::EMPTY_MAX;
      end
    end else begin
      state <= state_next;
      if (state == rnh_pkg::ST_SWEEP) sweep <= sweep + 1'b1;
      else sweep <= '0;
      if (accept && in_w.opcode == rnh_pkg::OP_CLEAR) begin
        for (int c = 0; c < rnh_pkg::CHANNELS; c++) begin
          cmin[c] <= rnh_pkg::EMPTY_MIN;
          cmax[c] <= rnh_pkg::EMPTY_MAX;
        end
      end else if (accept && in_w.opcode == rnh_pkg::OP_RANGE &&
                   32'(in_w.channel) < 32'(rnh_pkg::CHANNELS)) begin
        if (in_w.sample_value < cmin[in_w.channel]) cmin[in_w.channel] <= in_w.sample_value;
        if (in_w.sample_value > cmax[in_w.channel]) cmax[in_w.channel] <= in_w.sample_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= in_w.opcode;
      ch  <= in_w.channel;
      val <= in_w.sample_value;
      sel <= in_w.bin_select;
      idx <= in_w.bin_select;
    end else if (div_done) begin
      idx <= below ? '0 : div_q;
    end
  end

  always_comb begin
    res.bin_index   = (op == rnh_pkg::OP_BIN || op == rnh_pkg::OP_READ) ? idx : '0;
    res.bin_count   = '0;
    if (ch_ok && op == rnh_pkg::OP_BIN)
      res.bin_count = (rd_data == rnh_pkg::COUNT_MAX) ? rd_data : rd_data + 1'b1;
    else if (ch_ok && op == rnh_pkg::OP_READ && 32'(sel) < 32'(rnh_pkg::BINS))
      res.bin_count = rd_data;
    res.channel_min = ch_ok ? cmin[ch] : rnh_pkg::EMPTY_MIN;
    res.channel_max = ch_ok ? cmax[ch] : rnh_pkg::EMPTY_MAX;
    res.global_min  = gmin;
    res.global_max  = gmax;
  end

  assign out_w.bin_index   = res.bin_index;
  assign out_w.bin_count   = res.bin_count;
  assign out_w.channel_min = res.channel_min;
  assign out_w.channel_max = res.channel_max;
  assign out_w.global_min  = res.global_min;
  assign out_w.global_max  = res.global_max;
endmodule

### rtl/rnh_div.sv
// ----------------------------------------------------------------------------
// rnh_div
// Restoring divider, one quotient bit a cycle, quotient clamped to bins-1.
// ----------------------------------------------------------------------------
module rnh_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [rnh_pkg::PROD_BITS-1:0]       dividend,
  input  logic [32:0]                         divisor,
  output logic                                done,
  output logic [rnh_pkg::BIN_BITS-1:0]        quotient
);
  logic [rnh_pkg::PROD_BITS-1:0] quo;
  logic [33:0]                   rem;
  logic [32:0]                   dvs;
  logic [5:0]                    step;
  logic                          busy;
  logic [33:0]                   trial;
  logic [33:0]                   diff;

  always_comb begin
    trial = {rem[32:0], quo[rnh_pkg::PROD_BITS-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 6'(rnh_pkg::PROD_BITS);
      end else if (busy) begin
        step <= step - 6'd1;
        if (step == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[33]) begin
        rem <= diff;
        quo <= {quo[rnh_pkg::PROD_BITS-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[rnh_pkg::PROD_BITS-2:0], 1'b0};
      end
    end
  end

  // clamp to the top bin
  assign quotient = (quo > rnh_pkg::PROD_BITS'(rnh_pkg::BINS - 1))
                    ? rnh_pkg::BIN_BITS'(rnh_pkg::BINS - 1)
                    : quo[rnh_pkg::BIN_BITS-1:0];
endmodule
